### rtl/sbas_l1_frame_check_core_assert.svh
// Assertion macros for the SBAS L1 frame check core.
`ifndef SBAS_L1_FRAME_CHECK_CORE_ASSERT_SVH
`define SBAS_L1_FRAME_CHECK_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBASFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbasfc same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBASFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbasfc next-cycle check failed");

`endif

### rtl/sbasfc_pkg.sv
// Package for the SBAS L1 frame check: codes, constants, snapshot type, CRC-24Q.
`timescale 1ns / 1ps

package sbasfc_pkg;

  localparam logic [23:0] CRC_POLY        = 24'h864cfb;
  localparam logic [7:0]  PREAMBLE_A      = 8'h53;
  localparam logic [7:0]  PREAMBLE_B      = 8'h9a;
  localparam logic [7:0]  PREAMBLE_C      = 8'hc6;
  localparam int          CRC_BITS        = 226;
  localparam int          FRAME_BYTES     = 32;

  localparam logic [5:0]  HDR_BYTES       = 6'd3;
  localparam logic [5:0]  CRC_SPLIT_IDX   = 6'(CRC_BITS / 8);
  localparam logic [5:0]  LAST_BYTE_IDX   = 6'(FRAME_BYTES - 1);
  localparam logic [5:0]  IDX_MAX         = 6'h3f;

  localparam logic [5:0]  TYPE_MIXED_CORR = 6'd9;
  localparam logic [5:0]  TYPE_IGP_MASK   = 6'd18;
  localparam logic [5:0]  TYPE_IONO_DELAY = 6'd26;
  localparam logic [5:0]  TYPE_NULL       = 6'd63;
  localparam logic [3:0]  BAND_MAX        = 4'd10;
  localparam logic [3:0]  BLOCK_MAX       = 4'd13;

  typedef enum logic [2:0] {
    ST_DECODED         = 3'd0,
    ST_BYTE_COUNT      = 3'd1,
    ST_BAD_PREAMBLE    = 3'd2,
    ST_BAD_CRC         = 3'd3,
    ST_UNSUPPORTED     = 3'd4,
    ST_INVALID_CONTENT = 3'd5
  } status_t;

  // Frame state captured on the last byte, handed to the status stage.
  typedef struct packed {
    logic        count_ok;
    logic [23:0] header;
    logic [23:0] rx_crc;
    logic [23:0] calc_crc;
    logic [5:0]  padding;
  } snap_t;

  function automatic logic [23:0] crc24q_bit(input logic [23:0] crc, input logic din);
    logic fb;
    fb = crc[23] ^ din;
    crc24q_bit = {crc[22:0], 1'b0} ^ (fb ? CRC_POLY : 24'h0);
  endfunction

  // Eight bits, MSB first.
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] din);
    logic [23:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      c = crc24q_bit(c, din[i]);
    end
    crc24q_byte = c;
  endfunction

endpackage

### rtl/sbasfc_accum.sv
// Byte accumulator: byte count, running CRC-24Q, header/CRC/padding capture.
`timescale 1ns / 1ps

module sbasfc_accum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_end,
  input  logic               snap_take,
  output logic               snap_valid,
  output sbasfc_pkg::snap_t  snap
);
  import sbasfc_pkg::*;

  logic [5:0]  idx_r,  idx_nxt;
  logic [23:0] crc_r,  crc_nxt;
  logic [23:0] hdr_r,  hdr_nxt;
  logic [23:0] rxs_r,  rxs_nxt;
  logic [5:0]  pad_r,  pad_nxt;
  logic        snap_valid_r;
  snap_t       snap_r;
  logic        accept;

  assign in_stall = snap_valid_r && !snap_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hdr_nxt = hdr_r;
    crc_nxt = crc_r;
    rxs_nxt = rxs_r;
    pad_nxt = pad_r;
    idx_nxt = (idx_r == IDX_MAX) ? idx_r : idx_r + 6'd1;
    if (!idx_r[5]) begin
      if (idx_r < HDR_BYTES) begin
        hdr_nxt = {hdr_r[15:0], in_data_byte};
      end
      if (idx_r < CRC_SPLIT_IDX) begin
        crc_nxt = crc24q_byte(crc_r, in_data_byte);
      end else if (idx_r == CRC_SPLIT_IDX) begin
        // Two CRC-covered bits, then the first six received CRC bits.
        crc_nxt = crc24q_bit(crc24q_bit(crc_r, in_data_byte[7]), in_data_byte[6]);
        rxs_nxt = {rxs_r[17:0], in_data_byte[5:0]};
      end else if (idx_r < LAST_BYTE_IDX) begin
        rxs_nxt = {rxs_r[15:0], in_data_byte};
      end else begin
        rxs_nxt = {rxs_r[21:0], in_data_byte[7:6]};
        pad_nxt = in_data_byte[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      crc_r <= '0;
      hdr_r <= '0;
      rxs_r <= '0;
      pad_r <= '0;
    end else if (accept) begin
      if (in_frame_end) begin
        idx_r <= '0;
        crc_r <= '0;
        hdr_r <= '0;
        rxs_r <= '0;
        pad_r <= '0;
      end else begin
        idx_r <= idx_nxt;
        crc_r <= crc_nxt;
        hdr_r <= hdr_nxt;
        rxs_r <= rxs_nxt;
        pad_r <= pad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (accept && in_frame_end) begin
      snap_valid_r <= 1'b1;
    end else if (snap_take) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame_end) begin
      snap_r.count_ok <= (idx_r == LAST_BYTE_IDX);
      snap_r.header   <= hdr_nxt;
      snap_r.rx_crc   <= rxs_nxt;
      snap_r.calc_crc <= crc_nxt;
      snap_r.padding  <= pad_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

### rtl/sbas_l1_frame_check_core.sv
// Top level of the SBAS L1 frame check: accumulator plus status/result stage.
`timescale 1ns / 1ps

// SBAS L1 frame check. Feed a frame as bytes, MSB first, on in_data_byte and
// flag the final byte with in_frame_end; one result transfer follows per
// frame. The block runs CRC-24Q (poly 0x864cfb, zero init, no final xor) over
// frame bits 0..225 and compares it with the CRC carried in bits 226..249.
// Status priority: wrong byte count (frame not exactly 32 bytes; all other
// result fields zero), bad preamble (not 0x53/0x9a/0xc6), bad CRC, unsupported
// type (anything but 0-7, 9, 18, 26, 63), invalid content (band above 10, or
// type-26 block above 13). Bytes past the 32nd stay out of the CRC and the
// fields but make the byte count wrong. One byte is taken per clock, with no
// gaps between frames, while in_stall is low; the eight-bit unrolled CRC
// update in the accumulator is the longest path. Once the last byte
// transfers, the frame state is captured; its status is then decoded into
// the output register when that is empty or being drained. in_stall rises
// only when a captured frame and a held result are both waiting on out_stall.
module sbas_l1_frame_check_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_message_type,
  output logic [7:0]  out_preamble_value,
  output logic        out_preamble_ok,
  output logic [23:0] out_received_crc,
  output logic [23:0] out_computed_crc,
  output logic        out_crc_ok,
  output logic [5:0]  out_padding_value
);
  import sbasfc_pkg::*;

  `include "sbas_l1_frame_check_core_assert.svh"

  logic    snap_valid;
  snap_t   snap;
  logic    out_load;
  logic    snap_take;

  // Decoded result of the captured frame.
  status_t     st_nxt;
  logic [7:0]  pre;
  logic [5:0]  mtype;
  logic [3:0]  band18, band26, block26;
  logic        pok, cok;

  logic        out_valid_r;
  status_t     status_r;
  logic [5:0]  mtype_r;
  logic [7:0]  pre_r;
  logic        pok_r;
  logic [23:0] rx_crc_r;
  logic [23:0] calc_crc_r;
  logic        cok_r;
  logic [5:0]  pad_r;

  sbasfc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .snap_take    (snap_take),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  // Advance the output register whenever it is empty or being drained.
  assign out_load  = !out_valid_r || !out_stall;
  assign snap_take = snap_valid && out_load;

  assign pre     = snap.header[23:16];
  assign mtype   = snap.header[15:10];
  assign band18  = snap.header[5:2];
  assign band26  = snap.header[9:6];
  assign block26 = snap.header[5:2];
  assign pok     = (pre == PREAMBLE_A) || (pre == PREAMBLE_B) || (pre == PREAMBLE_C);
  assign cok     = (snap.rx_crc == snap.calc_crc);

  always_comb begin
    if (!snap.count_ok) begin
      st_nxt = ST_BYTE_COUNT;
    end else if (!pok) begin
      st_nxt = ST_BAD_PREAMBLE;
    end else if (!cok) begin
      st_nxt = ST_BAD_CRC;
    end else if (mtype inside {[6'd0:6'd7], TYPE_MIXED_CORR, TYPE_NULL}) begin
      st_nxt = ST_DECODED;
    end else if (mtype == TYPE_IGP_MASK) begin
      st_nxt = (band18 > BAND_MAX) ? ST_INVALID_CONTENT : ST_DECODED;
    end else if (mtype == TYPE_IONO_DELAY) begin
      st_nxt = (band26 > BAND_MAX || block26 > BLOCK_MAX) ? ST_INVALID_CONTENT
                                                          : ST_DECODED;
    end else begin
      st_nxt = ST_UNSUPPORTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= snap_valid;
    end
  end

  // Payload: wrong-length frames report zeros in every field but status.
  always_ff @(posedge clk) begin
    if (snap_take) begin
      status_r   <= st_nxt;
      mtype_r    <= snap.count_ok ? mtype : '0;
      pre_r      <= snap.count_ok ? pre : '0;
      pok_r      <= snap.count_ok && pok;
      rx_crc_r   <= snap.count_ok ? snap.rx_crc : '0;
      calc_crc_r <= snap.count_ok ? snap.calc_crc : '0;
      cok_r      <= snap.count_ok && cok;
      pad_r      <= snap.count_ok ? snap.padding : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_message_type   = mtype_r;
  assign out_preamble_value = pre_r;
  assign out_preamble_ok    = pok_r;
  assign out_received_crc   = rx_crc_r;
  assign out_computed_crc   = calc_crc_r;
  assign out_crc_ok         = cok_r;
  assign out_padding_value  = pad_r;

  // A wrong-length frame carries no CRC information.
  `SBASFC_ASSERT_NOW(a_count_zeroes, out_valid && out_status == ST_BYTE_COUNT, out_computed_crc == 24'h0 && !out_crc_ok && !out_preamble_ok)
  // A clean decode implies both the preamble and CRC checks passed.
  `SBASFC_ASSERT_NOW(a_decoded_checks, out_valid && out_status == ST_DECODED, out_preamble_ok && out_crc_ok && out_received_crc == out_computed_crc)
  // A good preamble never reports as a bad one.
  `SBASFC_ASSERT_NOW(a_preamble_flag, out_valid && out_preamble_ok, out_status != ST_BAD_PREAMBLE && out_status != ST_BYTE_COUNT)
  // A captured frame handed to the output stage shows up as a result.
  `SBASFC_ASSERT_NEXT(a_snap_to_out, snap_take, out_valid)

endmodule
